/* src/mixed_radix_up_down_timer_core_defines.svh */
// Assertion macros shared by the mixed-radix timer RTL.
// No dependencies; include after the timescale line.
`ifndef MIXED_RADIX_UP_DOWN_TIMER_CORE_DEFINES_SVH
`define MIXED_RADIX_UP_DOWN_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrt: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrt: next-cycle check failed");

`endif

/* src/mrt_pkg.sv */
// Package for the mixed-radix timer: radix constants, reciprocal constants,
// action codes and the request/result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrt_pkg;

   // Width of the stored day count.
   localparam int DAY_BITS = 16;
   localparam int DAY_W1   = DAY_BITS + 1;

   // Radix constants.
   localparam int MS_PER_SEC  = 1000;
   localparam int SEC_PER_MIN = 60;
   localparam int MIN_PER_HR  = 60;
   localparam int HR_PER_DAY  = 24;

   // Top values for loaded fields.
   localparam int HOUR_TOP   = 23;
   localparam int MINUTE_TOP = 59;
   localparam int SECOND_TOP = 59;
   localparam int MILLI_TOP  = 999;

   // Widths of the quotients of the tick split.
   localparam int QSEC_W = 23;
   localparam int QMIN_W = 17;
   localparam int QHR_W  = 11;
   localparam int QDAY_W = 6;

   // Exact reciprocals: floor(x * RECIP >> SHIFT) == x / divisor over the
   // full range of each quotient.
   localparam int unsigned RECIP_SEC = 32'd274877907;
   localparam int          SHIFT_SEC = 38;
   localparam int unsigned RECIP_MIN = 32'd8947849;
   localparam int          SHIFT_MIN = 29;
   localparam int unsigned RECIP_HR  = 32'd139811;
   localparam int          SHIFT_HR  = 23;
   localparam int unsigned RECIP_DAY = 32'd2731;
   localparam int          SHIFT_DAY = 16;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] delta_ms;
      logic [15:0] load_days;
      logic [4:0]  load_hours;
      logic [5:0]  load_minutes;
      logic [5:0]  load_seconds;
      logic [9:0]  load_millis;
   } req_item_type;

   // Request with its tick already split into mixed-radix digits.
   typedef struct packed {
      action_type         action;
      logic [15:0]        load_days;
      logic [4:0]         load_hours;
      logic [5:0]         load_minutes;
      logic [5:0]         load_seconds;
      logic [9:0]         load_millis;
      logic [QDAY_W-1:0]  d_days;
      logic [4:0]         d_hours;
      logic [5:0]         d_minutes;
      logic [5:0]         d_seconds;
      logic [9:0]         d_millis;
   } split_item_type;

   typedef struct packed {
      logic        expired;
      logic        is_null;
      logic [15:0] days_now;
      logic [4:0]  hours_now;
      logic [5:0]  minutes_now;
      logic [5:0]  seconds_now;
      logic [9:0]  millis_now;
   } rsp_item_type;

endpackage

`default_nettype wire

/* src/mixed_radix_up_down_timer_core.sv */
// Top level of the mixed-radix up/down timer core.
// Uses mrt_pkg, mrt_delta_split and mrt_time_update.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a time value as days, hours, minutes, seconds and milliseconds plus
// a null mark. Each request carries an action: a tick adds (count_down = 0)
// or subtracts (count_down = 1) its elapsed milliseconds, a load sets all
// fields with each one saturated to its top value, and a clear makes the
// timer null. Every request gives exactly one result holding the expiry
// flag and the state after the update. Counting up, the day count saturates
// while the lower fields keep their normal wrap; counting down past zero
// sets the null mark and flags expiry; ticks while null change nothing.
// Throughput is one request per clock while rsp_tready is high. Five stages
// split the tick into mixed-radix digits by reciprocal multiplication, and
// one register stage holds the timer state, which is also the result
// register. Only that last stage depends on the previous request, so
// requests issue back to back and the split pipeline keeps accepting while
// a result waits, until its stages are full. Reset takes effect at once;
// there is no clearing pass. Write count_down only while idle.
module mixed_radix_up_down_timer_core
   import mrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: count_down register.
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] delta_ms, [47:32] load_days, [52:48] load_hours,
   // [58:53] load_minutes, [64:59] load_seconds, [74:65] load_millis, rest 0
   input  wire logic [79:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] days_now, [20:16] hours_now, [26:21] minutes_now,
   // [32:27] seconds_now, [42:33] millis_now, rest 0
   output logic [47:0]      rsp_tdata,
   // [0] expired, [1] is_null
   output logic [1:0]       rsp_tuser
);

   logic           count_down_ff;
   req_item_type   req_item;
   split_item_type split_item;
   logic           split_valid;
   logic           split_ready;
   rsp_item_type   rsp_item;

   // Hold the mode; default after reset is counting down.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_down_ff <= 1'b1;
      end else if (csr_wr_en) begin
         count_down_ff <= csr_wr_data;
      end
   end

   // Unpack the request; action code three falls to the no-change arm.
   always_comb begin
      req_item.action       = action_type'(req_tuser);
      req_item.delta_ms     = req_tdata[31:0];
      req_item.load_days    = req_tdata[47:32];
      req_item.load_hours   = req_tdata[52:48];
      req_item.load_minutes = req_tdata[58:53];
      req_item.load_seconds = req_tdata[64:59];
      req_item.load_millis  = req_tdata[74:65];
   end

   // Split the tick into digits ahead of the state update.
   mrt_delta_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_item  (split_item)
   );

   // Apply the request to the timer state and present the result.
   mrt_time_update u_update (
      .clock      (clock),
      .reset      (reset),
      .count_down (count_down_ff),
      .in_valid   (split_valid),
      .in_ready   (split_ready),
      .in_item    (split_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result, padding tdata to whole bytes.
   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[15:0]  = rsp_item.days_now;
      rsp_tdata[20:16] = rsp_item.hours_now;
      rsp_tdata[26:21] = rsp_item.minutes_now;
      rsp_tdata[32:27] = rsp_item.seconds_now;
      rsp_tdata[42:33] = rsp_item.millis_now;
      rsp_tuser[0]     = rsp_item.expired;
      rsp_tuser[1]     = rsp_item.is_null;
   end

endmodule

`default_nettype wire

/* src/mrt_delta_split.sv */
// Five-stage pipeline that splits the tick into days, hours, minutes,
// seconds and milliseconds by reciprocal multiplication. Uses mrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrt_delta_split
   import mrt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire req_item_type   in_item,
   output logic                out_valid,
   input  wire logic           out_ready,
   output split_item_type      out_item
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   req_item_type item1_ff, item2_ff, item3_ff, item4_ff, item5_ff;

   logic [QSEC_W-1:0] qsec2_ff, qsec3_ff;
   logic [QMIN_W-1:0] qmin3_ff, qmin4_ff;
   logic [QHR_W-1:0]  qhr4_ff, qhr5_ff;
   logic [QDAY_W-1:0] qday5_ff;
   logic [9:0]        ms3_ff, ms4_ff, ms5_ff;
   logic [5:0]        sec4_ff, sec5_ff;
   logic [5:0]        min5_ff;

   logic [60:0]       prod1;
   logic [46:0]       prod2;
   logic [40:0]       prod3;
   logic [22:0]       prod4;
   logic [31:0]       ms_full;
   logic [QSEC_W-1:0] sec_full;
   logic [QMIN_W-1:0] min_full;
   logic [QHR_W-1:0]  hr_full;

   logic [QSEC_W-1:0] qsec_in;
   logic [QMIN_W-1:0] qmin_in;
   logic [QHR_W-1:0]  qhr_in;
   logic [QDAY_W-1:0] qday_in;
   logic [9:0]        ms_in;
   logic [5:0]        sec_in;
   logic [5:0]        min_in;
   logic [4:0]        hr_in;

   // A stage moves when it is empty or the one after it moves.
   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: seconds quotient.
   assign prod1   = 61'(item1_ff.delta_ms) * 61'(RECIP_SEC);
   assign qsec_in = prod1[SHIFT_SEC +: QSEC_W];

   // Stage 2: millisecond digit and minutes quotient.
   assign ms_full = item2_ff.delta_ms - 32'(qsec2_ff) * 32'(MS_PER_SEC);
   assign ms_in   = ms_full[9:0];
   assign prod2   = 47'(qsec2_ff) * 47'(RECIP_MIN);
   assign qmin_in = prod2[SHIFT_MIN +: QMIN_W];

   // Stage 3: second digit and hours quotient.
   assign sec_full = qsec3_ff - QSEC_W'(qmin3_ff) * QSEC_W'(SEC_PER_MIN);
   assign sec_in   = sec_full[5:0];
   assign prod3    = 41'(qmin3_ff) * 41'(RECIP_HR);
   assign qhr_in   = prod3[SHIFT_HR +: QHR_W];

   // Stage 4: minute digit and days quotient.
   assign min_full = qmin4_ff - QMIN_W'(qhr4_ff) * QMIN_W'(MIN_PER_HR);
   assign min_in   = min_full[5:0];
   assign prod4    = 23'(qhr4_ff) * 23'(RECIP_DAY);
   assign qday_in  = prod4[SHIFT_DAY +: QDAY_W];

   // Stage 5: hour digit.
   assign hr_full = qhr5_ff - QHR_W'(qday5_ff) * QHR_W'(HR_PER_DAY);
   assign hr_in   = hr_full[4:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         item1_ff <= in_item;
      end
      if (rdy2) begin
         item2_ff <= item1_ff;
         qsec2_ff <= qsec_in;
      end
      if (rdy3) begin
         item3_ff <= item2_ff;
         qsec3_ff <= qsec2_ff;
         qmin3_ff <= qmin_in;
         ms3_ff   <= ms_in;
      end
      if (rdy4) begin
         item4_ff <= item3_ff;
         qmin4_ff <= qmin3_ff;
         qhr4_ff  <= qhr_in;
         ms4_ff   <= ms3_ff;
         sec4_ff  <= sec_in;
      end
      if (rdy5) begin
         item5_ff <= item4_ff;
         qhr5_ff  <= qhr4_ff;
         qday5_ff <= qday_in;
         ms5_ff   <= ms4_ff;
         sec5_ff  <= sec4_ff;
         min5_ff  <= min_in;
      end
   end

   assign out_valid = v5_ff;

   always_comb begin
      out_item.action       = item5_ff.action;
      out_item.load_days    = item5_ff.load_days;
      out_item.load_hours   = item5_ff.load_hours;
      out_item.load_minutes = item5_ff.load_minutes;
      out_item.load_seconds = item5_ff.load_seconds;
      out_item.load_millis  = item5_ff.load_millis;
      out_item.d_days       = qday5_ff;
      out_item.d_hours      = hr_in;
      out_item.d_minutes    = min5_ff;
      out_item.d_seconds    = sec5_ff;
      out_item.d_millis     = ms5_ff;
   end

endmodule

`default_nettype wire

/* src/mrt_time_update.sv */
// Timer state and result register: mixed-radix add or subtract of the split
// tick, loads and clears. Uses mrt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mixed_radix_up_down_timer_core_defines.svh"

module mrt_time_update
   import mrt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             count_down,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire split_item_type   in_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_item_type          rsp_item
);

   logic [DAY_BITS-1:0] day_ff, day_in;
   logic [4:0]          hour_ff, hour_in;
   logic [5:0]          minute_ff, minute_in;
   logic [5:0]          second_ff, second_in;
   logic [9:0]          milli_ff, milli_in;
   logic                null_ff, null_in;
   logic                expired_ff, expired_in;
   logic                valid_ff, valid_in;
   logic                take;

   // Up path.
   logic [10:0]         up_ms_sum;
   logic [6:0]          up_sec_sum, up_min_sum;
   logic [5:0]          up_hr_sum;
   logic [DAY_W1-1:0]   up_day_sum;
   logic                c0, c1, c2, c3;
   logic [9:0]          up_ms;
   logic [5:0]          up_sec, up_min;
   logic [4:0]          up_hr;
   logic [DAY_BITS-1:0] up_day;

   // Down path.
   logic [6:0]          dn_sec_sub, dn_min_sub;
   logic [5:0]          dn_hr_sub;
   logic [DAY_W1-1:0]   dn_day_sub, dn_day_diff;
   logic                b0, b1, b2, b3, b4;
   logic [10:0]         dn_ms_w;
   logic [6:0]          dn_sec_w, dn_min_w;
   logic [5:0]          dn_hr_w;

   // Load saturation.
   logic [32:0]         load_day_w;
   logic [32:0]         day_max_w;
   logic [32:0]         day_out_w;

   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      up_ms_sum  = 11'(milli_ff) + 11'(in_item.d_millis);
      c0         = up_ms_sum >= 11'(MS_PER_SEC);
      up_ms      = c0 ? 10'(up_ms_sum - 11'(MS_PER_SEC)) : up_ms_sum[9:0];
      up_sec_sum = 7'(second_ff) + 7'(in_item.d_seconds) + 7'(c0);
      c1         = up_sec_sum >= 7'(SEC_PER_MIN);
      up_sec     = c1 ? 6'(up_sec_sum - 7'(SEC_PER_MIN)) : up_sec_sum[5:0];
      up_min_sum = 7'(minute_ff) + 7'(in_item.d_minutes) + 7'(c1);
      c2         = up_min_sum >= 7'(MIN_PER_HR);
      up_min     = c2 ? 6'(up_min_sum - 7'(MIN_PER_HR)) : up_min_sum[5:0];
      up_hr_sum  = 6'(hour_ff) + 6'(in_item.d_hours) + 6'(c2);
      c3         = up_hr_sum >= 6'(HR_PER_DAY);
      up_hr      = c3 ? 5'(up_hr_sum - 6'(HR_PER_DAY)) : up_hr_sum[4:0];
      up_day_sum = DAY_W1'(day_ff) + DAY_W1'(in_item.d_days) + DAY_W1'(c3);
      // Carry out of the day field: saturate.
      up_day     = up_day_sum[DAY_BITS] ? '1 : up_day_sum[DAY_BITS-1:0];
   end

   always_comb begin
      b0         = milli_ff < in_item.d_millis;
      dn_ms_w    = b0 ? 11'(milli_ff) + 11'(MS_PER_SEC) - 11'(in_item.d_millis)
                      : 11'(milli_ff) - 11'(in_item.d_millis);
      dn_sec_sub = 7'(in_item.d_seconds) + 7'(b0);
      b1         = 7'(second_ff) < dn_sec_sub;
      dn_sec_w   = b1 ? 7'(second_ff) + 7'(SEC_PER_MIN) - dn_sec_sub
                      : 7'(second_ff) - dn_sec_sub;
      dn_min_sub = 7'(in_item.d_minutes) + 7'(b1);
      b2         = 7'(minute_ff) < dn_min_sub;
      dn_min_w   = b2 ? 7'(minute_ff) + 7'(MIN_PER_HR) - dn_min_sub
                      : 7'(minute_ff) - dn_min_sub;
      dn_hr_sub  = 6'(in_item.d_hours) + 6'(b2);
      b3         = 6'(hour_ff) < dn_hr_sub;
      dn_hr_w    = b3 ? 6'(hour_ff) + 6'(HR_PER_DAY) - dn_hr_sub
                      : 6'(hour_ff) - dn_hr_sub;
      dn_day_sub = DAY_W1'(in_item.d_days) + DAY_W1'(b3);
      // Borrow out of the day field: the tick ran past zero.
      b4          = DAY_W1'(day_ff) < dn_day_sub;
      dn_day_diff = DAY_W1'(day_ff) - dn_day_sub;
   end

   assign load_day_w = 33'(in_item.load_days);
   assign day_max_w  = (33'(1) << DAY_BITS) - 33'(1);

   always_comb begin
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      milli_in   = milli_ff;
      null_in    = null_ff;
      expired_in = 1'b0;
      unique case (in_item.action)
         ACT_TICK: begin
            if (!null_ff) begin
               if (!count_down) begin
                  day_in    = up_day;
                  hour_in   = up_hr;
                  minute_in = up_min;
                  second_in = up_sec;
                  milli_in  = up_ms;
               end else if (b4) begin
                  day_in     = '0;
                  hour_in    = '0;
                  minute_in  = '0;
                  second_in  = '0;
                  milli_in   = '0;
                  null_in    = 1'b1;
                  expired_in = 1'b1;
               end else begin
                  day_in    = dn_day_diff[DAY_BITS-1:0];
                  hour_in   = dn_hr_w[4:0];
                  minute_in = dn_min_w[5:0];
                  second_in = dn_sec_w[5:0];
                  milli_in  = dn_ms_w[9:0];
               end
            end
         end
         ACT_LOAD: begin
            day_in    = (load_day_w > day_max_w) ? day_max_w[DAY_BITS-1:0]
                                                 : load_day_w[DAY_BITS-1:0];
            hour_in   = (in_item.load_hours > 5'(HOUR_TOP)) ? 5'(HOUR_TOP)
                                                            : in_item.load_hours;
            minute_in = (in_item.load_minutes > 6'(MINUTE_TOP)) ? 6'(MINUTE_TOP)
                                                                : in_item.load_minutes;
            second_in = (in_item.load_seconds > 6'(SECOND_TOP)) ? 6'(SECOND_TOP)
                                                                : in_item.load_seconds;
            milli_in  = (in_item.load_millis > 10'(MILLI_TOP)) ? 10'(MILLI_TOP)
                                                               : in_item.load_millis;
            null_in   = 1'b0;
         end
         ACT_CLEAR: begin
            day_in    = '0;
            hour_in   = '0;
            minute_in = '0;
            second_in = '0;
            milli_in  = '0;
            null_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (take) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         expired_ff <= 1'b0;
         null_ff    <= 1'b1;
         day_ff     <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         milli_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            expired_ff <= expired_in;
            null_ff    <= null_in;
            day_ff     <= day_in;
            hour_ff    <= hour_in;
            minute_ff  <= minute_in;
            second_ff  <= second_in;
            milli_ff   <= milli_in;
         end
      end
   end

   assign day_out_w = 33'(day_ff);
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_item.expired     = expired_ff;
      rsp_item.is_null     = null_ff;
      rsp_item.days_now    = day_out_w[15:0];
      rsp_item.hours_now   = hour_ff;
      rsp_item.minutes_now = minute_ff;
      rsp_item.seconds_now = second_ff;
      rsp_item.millis_now  = milli_ff;
   end

   `MRT_ASSERT_IMPLY(a_expired_means_null, clock, reset, expired_ff, null_ff)
   `MRT_ASSERT_IMPLY(a_null_fields_zero, clock, reset, null_ff,
      day_ff == '0 && hour_ff == '0 && minute_ff == '0 && second_ff == '0 && milli_ff == '0)
   `MRT_ASSERT_IMPLY(a_fields_in_range, clock, reset, 1'b1,
      hour_ff < 5'(HR_PER_DAY) && minute_ff < 6'(MIN_PER_HR) &&
      second_ff < 6'(SEC_PER_MIN) && milli_ff < 10'(MS_PER_SEC))
   `MRT_ASSERT_NEXT(a_clear_gives_null, clock, reset,
      take && in_item.action == ACT_CLEAR, null_ff && !expired_ff)
   `MRT_ASSERT_NEXT(a_no_expiry_counting_up, clock, reset, take && !count_down,
      !expired_ff)

endmodule

`default_nettype wire

/* verif/tb_mixed_radix_up_down_timer_core.sv */
// Self-checking testbench for the mixed-radix up/down timer core.
// Depends on mrt_pkg and mixed_radix_up_down_timer_core; drives random and
// directed requests over both count directions and checks every result.
`timescale 1ns / 1ps

module tb_mixed_radix_up_down_timer_core;
   import mrt_pkg::*;

   // Request as the testbench builds it; the action stays a raw code so the
   // unused code can be sent as well.
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] delta_ms;
      logic [15:0] load_days;
      logic [4:0]  load_hours;
      logic [5:0]  load_minutes;
      logic [5:0]  load_seconds;
      logic [9:0]  load_millis;
   } timer_req_type;

   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam longint unsigned MS_SEC  = MS_PER_SEC;
   localparam longint unsigned MS_MIN  = MS_SEC * SEC_PER_MIN;
   localparam longint unsigned MS_HR   = MS_MIN * MIN_PER_HR;
   localparam longint unsigned MS_DAY  = MS_HR * HR_PER_DAY;
   localparam longint unsigned DAY_TOP = (64'd1 << DAY_BITS) - 64'd1;

   localparam int PIPE_LATENCY = 6;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 430;

   // Clock, reset and all block inputs start at known values.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   mixed_radix_up_down_timer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Requests waiting for the driver, and results the timer still owes.
   timer_req_type req_backlog[$];
   rsp_item_type  owed_state_q[$];

   // Shadow copy of the timer: state plus the direction register.
   logic [DAY_BITS-1:0] tm_days;
   logic [4:0]          tm_hours;
   logic [5:0]          tm_minutes;
   logic [5:0]          tm_seconds;
   logic [9:0]          tm_millis;
   logic                tm_null;
   logic                tm_count_down;

   bit          idle_on = 1'b1;
   int unsigned send_gap;
   int unsigned sink_stall;
   int unsigned fail_count;
   int unsigned checked_count;
   int unsigned n_tick, n_load, n_clear, n_unused, n_expired, n_tick_up;

   // Shadow state follows the block's reset.
   initial begin
      tm_days       = '0;
      tm_hours      = '0;
      tm_minutes    = '0;
      tm_seconds    = '0;
      tm_millis     = '0;
      tm_null       = 1'b1;
      tm_count_down = 1'b1;
   end

   function automatic longint unsigned held_ms();
      return longint'(tm_days) * MS_DAY + longint'(tm_hours) * MS_HR +
             longint'(tm_minutes) * MS_MIN + longint'(tm_seconds) * MS_SEC +
             longint'(tm_millis);
   endfunction

   // Split a millisecond total into fields; saturate days, wrap the rest.
   function automatic void spread_ms(longint unsigned total);
      longint unsigned days;
      longint unsigned rest;
      days = total / MS_DAY;
      rest = total % MS_DAY;
      tm_days = (days > DAY_TOP) ? '1 : days[DAY_BITS-1:0];
      tm_hours = 5'(rest / MS_HR);
      rest = rest % MS_HR;
      tm_minutes = 6'(rest / MS_MIN);
      rest = rest % MS_MIN;
      tm_seconds = 6'(rest / MS_SEC);
      tm_millis = 10'(rest % MS_SEC);
   endfunction

   function automatic void zero_time();
      tm_days    = '0;
      tm_hours   = '0;
      tm_minutes = '0;
      tm_seconds = '0;
      tm_millis  = '0;
   endfunction

   // Advance the shadow timer by one request and return the state it shows.
   function automatic rsp_item_type timer_apply(timer_req_type rq);
      rsp_item_type    shown;
      longint unsigned now;
      shown.expired = 1'b0;
      if (rq.action == ACT_TICK) begin
         n_tick++;
         if (!tm_null) begin
            now = held_ms();
            if (tm_count_down) begin
               if (longint'(rq.delta_ms) > now) begin
                  zero_time();
                  tm_null = 1'b1;
                  shown.expired = 1'b1;
                  n_expired++;
               end else begin
                  spread_ms(now - longint'(rq.delta_ms));
               end
            end else begin
               n_tick_up++;
               spread_ms(now + longint'(rq.delta_ms));
            end
         end
      end else if (rq.action == ACT_LOAD) begin
         n_load++;
         tm_days = (longint'(rq.load_days) > DAY_TOP) ? '1 : DAY_BITS'(rq.load_days);
         tm_hours = (rq.load_hours > HOUR_TOP) ? 5'(HOUR_TOP) : rq.load_hours;
         tm_minutes = (rq.load_minutes > MINUTE_TOP) ? 6'(MINUTE_TOP) : rq.load_minutes;
         tm_seconds = (rq.load_seconds > SECOND_TOP) ? 6'(SECOND_TOP) : rq.load_seconds;
         tm_millis = (rq.load_millis > MILLI_TOP) ? 10'(MILLI_TOP) : rq.load_millis;
         tm_null = 1'b0;
      end else if (rq.action == ACT_CLEAR) begin
         n_clear++;
         zero_time();
         tm_null = 1'b1;
      end else begin
         n_unused++;
      end
      shown.is_null     = tm_null;
      shown.days_now    = 16'(tm_days);
      shown.hours_now   = tm_hours;
      shown.minutes_now = tm_minutes;
      shown.seconds_now = tm_seconds;
      shown.millis_now  = tm_millis;
      return shown;
   endfunction

   task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
      if (fail_count < 25)
         $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Driver: hold a request until taken, then optionally idle before the next one.
   always @(posedge clock) begin
      timer_req_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            rq = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= rq.action;
            req_tdata  <= {5'd0, rq.load_millis, rq.load_seconds, rq.load_minutes,
                           rq.load_hours, rq.load_days, rq.delta_ms};
            if (idle_on && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result,
   // and stall the result side in short bursts.
   always @(posedge clock) begin
      timer_req_type rq;
      rsp_item_type  want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.action       = req_tuser;
            rq.delta_ms     = req_tdata[31:0];
            rq.load_days    = req_tdata[47:32];
            rq.load_hours   = req_tdata[52:48];
            rq.load_minutes = req_tdata[58:53];
            rq.load_seconds = req_tdata[64:59];
            rq.load_millis  = req_tdata[74:65];
            owed_state_q.push_back(timer_apply(rq));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_state_q.size() == 0) begin
               flag_mismatch("result with nothing owed", 64'(rsp_tdata), 64'd0);
            end else begin
               want = owed_state_q.pop_front();
               checked_count++;
               if (rsp_tuser[0] !== want.expired)
                  flag_mismatch("expired", 64'(rsp_tuser[0]), 64'(want.expired));
               if (rsp_tuser[1] !== want.is_null)
                  flag_mismatch("is_null", 64'(rsp_tuser[1]), 64'(want.is_null));
               if (rsp_tdata[15:0] !== want.days_now)
                  flag_mismatch("days_now", 64'(rsp_tdata[15:0]), 64'(want.days_now));
               if (rsp_tdata[20:16] !== want.hours_now)
                  flag_mismatch("hours_now", 64'(rsp_tdata[20:16]), 64'(want.hours_now));
               if (rsp_tdata[26:21] !== want.minutes_now)
                  flag_mismatch("minutes_now", 64'(rsp_tdata[26:21]),
                                64'(want.minutes_now));
               if (rsp_tdata[32:27] !== want.seconds_now)
                  flag_mismatch("seconds_now", 64'(rsp_tdata[32:27]),
                                64'(want.seconds_now));
               if (rsp_tdata[42:33] !== want.millis_now)
                  flag_mismatch("millis_now", 64'(rsp_tdata[42:33]),
                                64'(want.millis_now));
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles", STALL_LIMIT);
      $display("mixed_radix_up_down_timer_core: mismatch");
      $finish;
   end

   function automatic timer_req_type make_req(logic [1:0] act, logic [31:0] delta,
                                              logic [15:0] d, logic [4:0] h,
                                              logic [5:0] m, logic [5:0] s,
                                              logic [9:0] ms);
      timer_req_type rq;
      rq.action       = act;
      rq.delta_ms     = delta;
      rq.load_days    = d;
      rq.load_hours   = h;
      rq.load_minutes = m;
      rq.load_seconds = s;
      rq.load_millis  = ms;
      return rq;
   endfunction

   function automatic void send_tick(logic [31:0] delta);
      req_backlog.push_back(make_req(ACT_TICK, delta, '0, '0, '0, '0, '0));
   endfunction

   function automatic void send_load(logic [15:0] d, logic [4:0] h, logic [5:0] m,
                                     logic [5:0] s, logic [9:0] ms);
      req_backlog.push_back(make_req(ACT_LOAD, '0, d, h, m, s, ms));
   endfunction

   // Random request: mostly ticks on a loaded timer, with loads that keep
   // the time short enough to expire, some out-of-range loads, and noise.
   function automatic timer_req_type rand_request();
      timer_req_type rq;
      int unsigned   pick;
      rq = make_req(ACT_TICK, $urandom, 16'($urandom), 5'($urandom), 6'($urandom),
                    6'($urandom), 10'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         rq.action = ACT_LOAD;
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 3))
               0: rq.load_days = 16'($urandom_range(0, 3));
               1: rq.load_days = 16'($urandom_range(0, 60));
               2: rq.load_days = 16'($urandom);
               default: rq.load_days = 16'hFFFF;
            endcase
            rq.load_hours   = 5'($urandom_range(0, HOUR_TOP));
            rq.load_minutes = 6'($urandom_range(0, MINUTE_TOP));
            rq.load_seconds = 6'($urandom_range(0, SECOND_TOP));
            rq.load_millis  = 10'($urandom_range(0, MILLI_TOP));
         end
      end else if (pick < 19) begin
         rq.action = ACT_CLEAR;
      end else if (pick < 22) begin
         rq.action = ACT_UNUSED;
      end else begin
         case ($urandom_range(0, 9))
            0: rq.delta_ms = 32'd0;
            1: rq.delta_ms = 32'hFFFF_FFFF;
            2, 3: rq.delta_ms = $urandom;
            4, 5, 6: rq.delta_ms = $urandom_range(1, 2000);
            default: rq.delta_ms = $urandom_range(0, 100_000_000);
         endcase
      end
      return rq;
   endfunction

   // Wait until the sender is empty and every owed result has arrived,
   // then let the pipeline settle.
   task automatic drain_all();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || owed_state_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_direction(bit down);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= down;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tm_count_down = down;
   endtask

   task automatic random_phase(int unsigned count, bit pause_midway);
      for (int unsigned i = 0; i < count; i++) begin
         req_backlog.push_back(rand_request());
         if (pause_midway && i == count / 2)
            drain_all();
      end
      drain_all();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Count down (reset value): tick while null, exact zero, zero tick,
      // expiry, largest tick, unused code, out-of-range load, clear.
      send_tick(32'd5);
      send_load(16'd0, 5'd0, 6'd0, 6'd1, 10'd500);
      send_tick(32'd1500);
      send_tick(32'd0);
      send_tick(32'd1);
      send_load(16'hFFFF, 5'd23, 6'd59, 6'd59, 10'd999);
      send_tick(32'hFFFF_FFFF);
      req_backlog.push_back(make_req(ACT_UNUSED, 32'd77, '0, '0, '0, '0, '0));
      send_load(16'hFFFF, 5'h1F, 6'h3F, 6'h3F, 10'h3FF);
      req_backlog.push_back(make_req(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
      send_tick(32'd7);
      drain_all();

      // Count up: tick while null, day rollover, day saturation with wrap.
      set_direction(1'b0);
      send_tick(32'd9);
      send_load(16'd0, 5'd0, 6'd0, 6'd0, 10'd0);
      send_tick(32'd0);
      send_tick(32'd86_399_999);
      send_tick(32'd1);
      send_load(16'hFFFF, 5'd23, 6'd59, 6'd59, 10'd999);
      send_tick(32'd1);
      send_tick(32'hFFFF_FFFF);
      req_backlog.push_back(make_req(ACT_UNUSED, 32'd3, '0, '0, '0, '0, '0));
      req_backlog.push_back(make_req(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
      drain_all();

      set_direction(1'b1);
      random_phase(PHASE_ITEMS, 1'b1);
      set_direction(1'b0);
      random_phase(PHASE_ITEMS, 1'b0);

      // Run the last stretch at full rate on both sides.
      idle_on = 1'b0;
      set_direction(1'b1);
      random_phase(PHASE_ITEMS, 1'b0);

      if (owed_state_q.size() != 0)
         flag_mismatch("results never returned", 64'(owed_state_q.size()), 64'd0);
      $display("covered %0d ticks (%0d up-count, %0d expiries), %0d loads, %0d clears, %0d unused",
               n_tick, n_tick_up, n_expired, n_load, n_clear, n_unused);
      $display("checked %0d results in both directions, %0d mismatches",
               checked_count, fail_count);
      if (fail_count == 0)
         $display("mixed_radix_up_down_timer_core: match");
      else
         $display("mixed_radix_up_down_timer_core: mismatch");
      $finish;
   end

endmodule
